### hdl/plr_pkg.sv
// ----------------------------------------------------------------------------
// plr_pkg: shared types and helpers for the Playfair digraph encryptor
// Letter codes, item kinds, the controller/datapath command and status
// bundles, and the small grid arithmetic used on cell positions.
// ----------------------------------------------------------------------------
`default_nettype none

package plr_pkg;

    localparam int ALPHA = 26;
    localparam int CELLS = 25;

    localparam logic [4:0] LTR_I = 5'd8;
    localparam logic [4:0] LTR_J = 5'd9;
    localparam logic [4:0] LTR_X = 5'd23;
    localparam logic [4:0] LTR_Z = 5'd25;

    typedef enum logic [1:0] {
        KIND_KEY  = 2'd0,
        KIND_SEAL = 2'd1,
        KIND_TEXT = 2'd2,
        KIND_END  = 2'd3
    } kind_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch the incoming item
        logic place_key;    // place the latched keyword letter
        logic seal_step;    // place the next alphabet letter while sealing
        logic set_pending;  // hold the latched text letter as a lone letter
        logic start_pair;   // form the digraph and read both positions
        logic read_grid;    // look up both cipher letters
        logic load_out;     // load one cipher letter into the output register
        logic out_second;   // which letter of the digraph to load
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        kind_t kind;
        logic  bad;         // latched letter code is out of range
        logic  sealed;
        logic  pending;
        logic  seal_last;   // sealing walk is on its final letter
        logic  out_free;    // output register can take a letter this cycle
    } sts_t;

    // Row of a cell position 0..24
    function automatic logic [2:0] pos_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    // Column of a cell position 0..24
    function automatic logic [2:0] pos_col(input logic [4:0] p);
        logic [2:0] r;
        logic [4:0] base;
        r    = pos_row(p);
        base = ({2'b00, r} << 2) + {2'b00, r};
        return 3'(p - base);
    endfunction

    // Step one place along a row or column, wrapping at the edge
    function automatic logic [2:0] inc5(input logic [2:0] v);
        return (v == 3'd4) ? 3'd0 : 3'(v + 3'd1);
    endfunction

    // Cell position from row and column
    function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
        return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

`default_nettype wire

### hdl/plr_datapath.sv
// ----------------------------------------------------------------------------
// plr_datapath: table storage, digraph lookup and output register
// Holds the 5x5 grid and letter position memories, the taken bits, the fill
// count, the sealing walk counter, the lone letter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plr_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [1:0]    kind,
    input  wire logic [4:0]    letter,
    input  wire plr_pkg::cmd_t cmd,
    output plr_pkg::sts_t      sts,
    input  wire logic          out_stall,
    output logic               out_valid,
    output logic [4:0]         cipher_letter,
    output logic               last_of_pair
);
    import plr_pkg::*;

    // Memories
    logic [4:0] grid_mem [CELLS];
    logic [4:0] pos_mem  [ALPHA];

    // Control state
    logic [ALPHA-1:0] taken_reg;
    logic [4:0]       fill_count_reg;
    logic             sealed_reg;
    logic             pending_valid_reg;
    logic [4:0]       seal_letter_reg;
    logic             out_valid_reg;

    // Payload registers
    kind_t      item_kind_reg;
    logic [4:0] item_letter_reg;
    logic       item_bad_reg;
    logic [4:0] pending_letter_reg;
    logic [4:0] pos_a_reg;
    logic [4:0] pos_b_reg;
    logic [4:0] enc_a_reg;
    logic [4:0] enc_b_reg;
    logic [4:0] out_letter_reg;
    logic       out_last_reg;

    logic [4:0] wr_letter;
    logic       place_en;
    logic       pair_double;
    logic [4:0] pair_a;
    logic [4:0] pair_b;
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] idx_a, idx_b;
    logic       out_taken;

    // Select the letter to place and check that it may go in
    assign wr_letter = cmd.seal_step ? seal_letter_reg : item_letter_reg;
    assign place_en  = (cmd.place_key || (cmd.seal_step && seal_letter_reg != LTR_J))
                       && !taken_reg[wr_letter] && (fill_count_reg < 5'(CELLS));

    // Form the digraph: a doubled letter takes a filler, a lone letter a pad
    assign pair_double = (item_kind_reg == KIND_TEXT) && (pending_letter_reg == item_letter_reg);
    always_comb
    begin
        if (item_kind_reg == KIND_END)
        begin
            pair_a = pending_letter_reg;
            pair_b = (pending_letter_reg == LTR_Z) ? LTR_X : LTR_Z;
        end
        else if (pair_double)
        begin
            pair_a = item_letter_reg;
            pair_b = (item_letter_reg == LTR_X) ? LTR_Z : LTR_X;
        end
        else
        begin
            pair_a = pending_letter_reg;
            pair_b = item_letter_reg;
        end
    end

    // Apply the same-row, same-column or rectangle rule
    assign ra = pos_row(pos_a_reg);
    assign ca = pos_col(pos_a_reg);
    assign rb = pos_row(pos_b_reg);
    assign cb = pos_col(pos_b_reg);
    always_comb
    begin
        if (ra == rb)
        begin
            idx_a = cell_index(ra, inc5(ca));
            idx_b = cell_index(rb, inc5(cb));
        end
        else if (ca == cb)
        begin
            idx_a = cell_index(inc5(ra), ca);
            idx_b = cell_index(inc5(rb), cb);
        end
        else
        begin
            idx_a = cell_index(ra, cb);
            idx_b = cell_index(rb, ca);
        end
    end

    assign out_taken = out_valid_reg && !out_stall;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg         <= '0;
            fill_count_reg    <= '0;
            sealed_reg        <= 1'b0;
            pending_valid_reg <= 1'b0;
            seal_letter_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (place_en)
            begin
                taken_reg[wr_letter] <= 1'b1;
                fill_count_reg       <= fill_count_reg + 5'd1;
            end
            if (cmd.capture)
                seal_letter_reg <= '0;
            else if (cmd.seal_step)
                seal_letter_reg <= seal_letter_reg + 5'd1;
            if (cmd.seal_step && seal_letter_reg == LTR_Z)
                sealed_reg <= 1'b1;
            if (cmd.set_pending)
                pending_valid_reg <= 1'b1;
            else if (cmd.start_pair && !pair_double)
                pending_valid_reg <= 1'b0;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_taken)
                out_valid_reg <= 1'b0;
        end
    end

    // Write and read the table memories, advance the payload registers
    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            grid_mem[fill_count_reg] <= wr_letter;
            pos_mem[wr_letter]       <= fill_count_reg;
        end
        if (cmd.capture)
        begin
            item_kind_reg   <= kind_t'(kind);
            item_bad_reg    <= (letter > LTR_Z);
            item_letter_reg <= (letter == LTR_J) ? LTR_I : letter;
        end
        if (cmd.set_pending)
            pending_letter_reg <= item_letter_reg;
        if (cmd.start_pair)
        begin
            pos_a_reg <= pos_mem[pair_a];
            pos_b_reg <= pos_mem[pair_b];
        end
        if (cmd.read_grid)
        begin
            enc_a_reg <= grid_mem[idx_a];
            enc_b_reg <= grid_mem[idx_b];
        end
        if (cmd.load_out)
        begin
            out_letter_reg <= cmd.out_second ? enc_b_reg : enc_a_reg;
            out_last_reg   <= cmd.out_second;
        end
    end

    assign sts.kind      = item_kind_reg;
    assign sts.bad       = item_bad_reg;
    assign sts.sealed    = sealed_reg;
    assign sts.pending   = pending_valid_reg;
    assign sts.seal_last = (seal_letter_reg == LTR_Z);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign cipher_letter = out_letter_reg;
    assign last_of_pair  = out_last_reg;

    // Checks
    a_sealed_full: assert property (@(posedge clk) disable iff (!rst_n)
        sealed_reg |-> fill_count_reg == 5'(CELLS))
        else $error("sealed table is not full");
    a_no_place_sealed: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.place_key || cmd.seal_step) |-> !sealed_reg)
        else $error("table written after sealing");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while stalled");
    a_second_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && cmd.out_second) |=> (out_valid_reg && out_last_reg))
        else $error("second letter not flagged");

endmodule

`default_nettype wire

### hdl/plr_controller.sv
// ----------------------------------------------------------------------------
// plr_controller: item sequencer for the Playfair digraph encryptor
// Takes one item at a time, runs the sealing walk when needed, and steps a
// digraph through position lookup, grid lookup and the two output letters.
// ----------------------------------------------------------------------------
`default_nettype none

module plr_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire plr_pkg::sts_t sts,
    output plr_pkg::cmd_t      cmd
);
    import plr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEAL,
        S_GRID,
        S_OUT0,
        S_OUT1
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode the state into commands and the next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (sts.kind)
                    KIND_KEY:
                    begin
                        cmd.place_key = !sts.bad && !sts.sealed;
                    end
                    KIND_SEAL:
                    begin
                        if (!sts.sealed)
                            state_next = S_SEAL;
                    end
                    KIND_TEXT:
                    begin
                        if (sts.bad)
                            state_next = S_IDLE;
                        else if (!sts.sealed)
                            state_next = S_SEAL;
                        else if (!sts.pending)
                            cmd.set_pending = 1'b1;
                        else
                        begin
                            cmd.start_pair = 1'b1;
                            state_next     = S_GRID;
                        end
                    end
                    KIND_END:
                    begin
                        if (sts.pending)
                        begin
                            cmd.start_pair = 1'b1;
                            state_next     = S_GRID;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SEAL:
            begin
                cmd.seal_step = 1'b1;
                if (sts.seal_last)
                    state_next = (sts.kind == KIND_TEXT) ? S_EXEC : S_IDLE;
            end
            S_GRID:
            begin
                cmd.read_grid = 1'b1;
                state_next    = S_OUT0;
            end
            S_OUT0:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_OUT1;
                end
            end
            S_OUT1:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_second = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    // Checks
    a_seal_unsealed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEAL) |-> !sts.sealed)
        else $error("sealing walk on a sealed table");
    a_pair_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_pair |-> (sts.sealed && sts.pending))
        else $error("digraph started without table or lone letter");
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && !cmd.out_second) |=> (state_reg == S_OUT1))
        else $error("second letter not next after the first");

endmodule

`default_nettype wire

### hdl/playfair_digraph_encryptor_top.sv
// A text letter that completes a digraph steps through the execute, grid lookup
//   and two output states; each cipher letter waits while the output stalls.
//   A new item is taken only in the idle state, after the last one is through.
// Sealing adds a walk over the alphabet; a text letter that seals then executes.
// Reset is asynchronous and clears the taken bits, fill count and all control.
// The grid and position memories are not cleared; they are read only when full.
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor_top: Playfair digraph encryptor
// Builds a 5x5 key table from keyword letters and encrypts text letters in
// pairs, one cipher letter per output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_encryptor_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] kind,
    input  wire logic [4:0] letter,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [4:0]      cipher_letter,
    output logic            last_of_pair
);
    import plr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    plr_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    plr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .kind          (kind),
        .letter        (letter),
        .cmd           (cmd),
        .sts           (sts),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .cipher_letter (cipher_letter),
        .last_of_pair  (last_of_pair)
    );

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Playfair digraph encryptor
// Builds one key table from a directed and a random keyword, then sends a
// short table of directed items and about a hundred random messages. Every
// input transfer updates a behavioral copy of the encryptor, which queues the
// cipher letters it predicts; output transfers are checked against that queue
// in order, with random idle bursts on the input side and random stalls on
// the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import plr_pkg::*;

    localparam int         GRID_SIDE    = 5;
    localparam int         RANDOM_ITEMS = 750;
    localparam int         QUIET_TAIL   = 100;
    localparam int         DRAIN_CYCLES = 40;
    localparam logic [4:0] LTR_A        = 5'd0;
    localparam logic [4:0] LTR_BAD      = 5'd26;   // lowest out-of-range code
    localparam logic [4:0] LTR_MAX      = 5'd31;   // all ones, out of range

    typedef struct packed {
        logic [4:0] cipher_letter;
        logic       last_of_pair;
    } cipher_t;

    typedef struct packed {
        kind_t      kind;
        logic [4:0] letter;
        logic       quiet;      // row is known to give no cipher letter
    } step_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    kind_t      kind;
    logic [4:0] letter;
    logic       out_valid;
    logic       out_stall;
    logic [4:0] cipher_letter;
    logic       last_of_pair;

    bit         idle_en;
    int         mismatches;

    // Behavioral copy of the encryptor state
    logic [4:0] key_grid [CELLS];
    logic [4:0] key_pos [ALPHA];
    bit         key_taken [ALPHA];
    int         key_fill;
    bit         grid_sealed;
    bit         lone_valid;
    logic [4:0] lone_letter;
    cipher_t    cipher_q [$];

    // Keyword corner cases, sent before any table is sealed
    step_row_t opening_rows [7] = '{
        '{KIND_KEY,  LTR_Z,   1'b1},
        '{KIND_KEY,  LTR_A,   1'b1},
        '{KIND_KEY,  LTR_J,   1'b1},
        '{KIND_KEY,  LTR_I,   1'b1},
        '{KIND_KEY,  LTR_MAX, 1'b1},
        '{KIND_TEXT, LTR_BAD, 1'b1},
        '{KIND_END,  LTR_MAX, 1'b1}
    };

    // Text corner cases: folding, fillers, padding, ignored items
    step_row_t message_rows [19] = '{
        '{KIND_TEXT, LTR_J,   1'b1},
        '{KIND_SEAL, LTR_A,   1'b1},
        '{KIND_KEY,  LTR_X,   1'b1},
        '{KIND_TEXT, LTR_I,   1'b0},
        '{KIND_TEXT, LTR_X,   1'b0},
        '{KIND_TEXT, LTR_X,   1'b0},
        '{KIND_TEXT, LTR_X,   1'b0},
        '{KIND_TEXT, LTR_Z,   1'b0},
        '{KIND_END,  LTR_A,   1'b1},
        '{KIND_TEXT, LTR_Z,   1'b0},
        '{KIND_END,  LTR_MAX, 1'b0},
        '{KIND_TEXT, LTR_A,   1'b0},
        '{KIND_END,  LTR_A,   1'b0},
        '{KIND_TEXT, LTR_A,   1'b0},
        '{KIND_TEXT, LTR_MAX, 1'b1},
        '{KIND_TEXT, LTR_Z,   1'b0},
        '{KIND_TEXT, LTR_Z,   1'b0},
        '{KIND_TEXT, LTR_Z,   1'b0},
        '{KIND_END,  LTR_A,   1'b0}
    };

    playfair_digraph_encryptor_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .letter        (letter),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cipher_letter (cipher_letter),
        .last_of_pair  (last_of_pair)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Add a letter to the key table unless it is already there or full
    function automatic void place_letter(input logic [4:0] l);
        if (l >= ALPHA || key_taken[l] || key_fill >= CELLS)
            return;
        key_grid[key_fill] = l;
        key_pos[l]         = 5'(key_fill);
        key_taken[l]       = 1'b1;
        key_fill++;
    endfunction

    // Append the unused alphabet, J excluded
    function automatic void seal_grid();
        if (grid_sealed)
            return;
        for (int l = 0; l < ALPHA; l++)
            if (5'(l) != LTR_J)
                place_letter(5'(l));
        grid_sealed = 1'b1;
    endfunction

    // Encrypt one digraph and queue its two cipher letters when keep is set
    function automatic void encrypt_pair(input logic [4:0] a, input logic [4:0] b,
                                         input bit keep);
        int         ra, ca, rb, cb;
        logic [4:0] ea, eb;
        ra = key_pos[a] / GRID_SIDE;
        ca = key_pos[a] % GRID_SIDE;
        rb = key_pos[b] / GRID_SIDE;
        cb = key_pos[b] % GRID_SIDE;
        if (ra == rb)
        begin
            ea = key_grid[ra * GRID_SIDE + (ca + 1) % GRID_SIDE];
            eb = key_grid[rb * GRID_SIDE + (cb + 1) % GRID_SIDE];
        end
        else if (ca == cb)
        begin
            ea = key_grid[((ra + 1) % GRID_SIDE) * GRID_SIDE + ca];
            eb = key_grid[((rb + 1) % GRID_SIDE) * GRID_SIDE + cb];
        end
        else
        begin
            ea = key_grid[ra * GRID_SIDE + cb];
            eb = key_grid[rb * GRID_SIDE + ca];
        end
        if (keep)
        begin
            cipher_q.push_back(cipher_t'{ea, 1'b0});
            cipher_q.push_back(cipher_t'{eb, 1'b1});
        end
    endfunction

    // Advance the behavioral copy by one accepted item
    function automatic void predict_item(input kind_t k, input logic [4:0] l, input bit keep);
        logic [4:0] f;
        f = l;
        if (k == KIND_KEY || k == KIND_TEXT)
        begin
            if (l >= ALPHA)
                return;
            if (l == LTR_J)
                f = LTR_I;
        end
        case (k)
            KIND_KEY:
                if (!grid_sealed)
                    place_letter(f);
            KIND_SEAL:
                seal_grid();
            KIND_TEXT:
            begin
                seal_grid();
                if (!lone_valid)
                begin
                    lone_valid  = 1'b1;
                    lone_letter = f;
                end
                else if (lone_letter == f)
                    encrypt_pair(f, (f == LTR_X) ? LTR_Z : LTR_X, keep);
                else
                begin
                    lone_valid = 1'b0;
                    encrypt_pair(lone_letter, f, keep);
                end
            end
            default:
                if (lone_valid)
                begin
                    lone_valid = 1'b0;
                    encrypt_pair(lone_letter, (lone_letter == LTR_Z) ? LTR_X : LTR_Z, keep);
                end
        endcase
    endfunction

    // Offer one item, hold it until the transfer, then predict
    task automatic transfer_item(input kind_t k, input logic [4:0] l, input bit keep);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        letter   <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(k, l, keep);
    endtask

    // Pick a text letter, leaning on doubles and the filler letters
    function automatic logic [4:0] pick_text(input logic [4:0] prev);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return prev;
        if (r < 35)
        begin
            case ($urandom_range(0, 3))
                0: return LTR_X;
                1: return LTR_Z;
                2: return LTR_J;
                default: return LTR_I;
            endcase
        end
        return 5'($urandom_range(0, ALPHA - 1));
    endfunction

    initial
    begin : stimulus
        int unsigned n_key;
        int unsigned len;
        int          counted;
        logic [4:0]  prev;
        logic [4:0]  cur;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_KEY;
        letter      = LTR_A;
        idle_en     = 1'b1;
        mismatches  = 0;
        key_fill    = 0;
        grid_sealed = 1'b0;
        lone_valid  = 1'b0;
        lone_letter = LTR_A;
        foreach (key_taken[i])
            key_taken[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the keyword corner cases
        foreach (opening_rows[i])
            transfer_item(opening_rows[i].kind, opening_rows[i].letter, !opening_rows[i].quiet);

        // Random keyword: usually short, sometimes long enough to fill the table
        n_key = ($urandom_range(0, 2) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 12);
        repeat (n_key)
            transfer_item(KIND_KEY, 5'($urandom_range(0, ALPHA - 1)), 1'b1);

        // Seal explicitly, or leave it to the first text letter
        if ($urandom_range(0, 1) == 1)
            transfer_item(KIND_SEAL, 5'($urandom), 1'b1);

        foreach (message_rows[i])
            transfer_item(message_rows[i].kind, message_rows[i].letter, !message_rows[i].quiet);

        // Random messages with some noise between them
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            idle_en = (counted < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: transfer_item(KIND_KEY, 5'($urandom), 1'b1);
                    1: transfer_item(KIND_SEAL, 5'($urandom), 1'b1);
                    2: transfer_item(KIND_END, 5'($urandom), 1'b1);
                    default: transfer_item(KIND_TEXT, 5'($urandom_range(ALPHA, 31)), 1'b1);
                endcase
            end
            else
            begin
                len  = $urandom_range(1, 12);
                prev = 5'($urandom_range(0, ALPHA - 1));
                repeat (len)
                begin
                    cur = pick_text(prev);
                    if ($urandom_range(0, 19) == 0)
                        transfer_item(KIND_TEXT, 5'($urandom_range(ALPHA, 31)), 1'b1);
                    transfer_item(KIND_TEXT, cur, 1'b1);
                    prev = cur;
                    counted++;
                end
                if ($urandom_range(0, 6) != 0)
                begin
                    transfer_item(KIND_END, 5'($urandom), 1'b1);
                    counted++;
                end
            end
        end
        idle_en = 1'b0;
        in_valid <= 1'b0;

        // Drain outstanding cipher letters, then watch for strays
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Stall the output side in random bursts
    initial
    begin : stall_gen
        int unsigned n;
        bit          s;
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!idle_en)
            begin
                s = 1'b0;
                n = 1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                s = 1'b1;
                n = $urandom_range(1, 14);
            end
            else
            begin
                s = 1'b0;
                n = $urandom_range(1, 30);
            end
            repeat (n)
            begin
                out_stall <= s;
                @(posedge clk);
            end
        end
    end

    // Check each output transfer against the oldest predicted letter
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_q.size() == 0)
            begin
                $display("%0t: unexpected cipher letter %0d last_of_pair %0b, expected none",
                         $time, cipher_letter, last_of_pair);
                mismatches++;
            end
            else
            begin
                if (cipher_letter !== cipher_q[0].cipher_letter)
                begin
                    $display("%0t: cipher_letter expected %0d, actual %0d",
                             $time, cipher_q[0].cipher_letter, cipher_letter);
                    mismatches++;
                end
                if (last_of_pair !== cipher_q[0].last_of_pair)
                begin
                    $display("%0t: last_of_pair expected %0b, actual %0b",
                             $time, cipher_q[0].last_of_pair, last_of_pair);
                    mismatches++;
                end
                void'(cipher_q.pop_front());
            end
        end
    end

    // Stop a hung run
    initial
    begin : watchdog
        #(5_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### playfair_digraph_encryptor_top.f
hdl/plr_pkg.sv
hdl/plr_datapath.sv
hdl/plr_controller.sv
hdl/playfair_digraph_encryptor_top.sv
tb/sv/tb.sv
